// File: design/ebt_pkg.sv
// Package for the epistasis bit transform: sizes, register indexes, reset values
// and the per-lane configuration record. No dependencies.
package ebt_pkg;

    localparam int MAX_LEN    = 64;
    localparam int POS_W      = 6;
    localparam int LEN_W      = 7;
    localparam int EXT_W      = LEN_W + 1;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VECTOR_LENGTH = CFG_IDX_W'(1);

    localparam logic [LEN_W-1:0] RST_BLOCK_LENGTH  = LEN_W'(4);
    localparam logic [LEN_W-1:0] RST_VECTOR_LENGTH = LEN_W'(64);

    // What one lane needs to know about its bit position
    typedef struct packed {
        logic             valid;     // position below vector length
        logic             has_excl;  // not the last position of its block
        logic [POS_W-1:0] first_pos; // first position of the block
        logic [POS_W-1:0] last_pos;  // last position of the block
        logic [POS_W-1:0] excl_pos;  // excluded bit
    } t_lane_cfg;

endpackage

// File: design/ebt_setup.sv
// Configuration registers and the lane table builder for the epistasis transform.
// Sweeps all bit positions once after reset and after each register write.
// Depends on ebt_pkg.
module ebt_setup import ebt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output t_lane_cfg             o_lane_cfg [MAX_LEN]
);

    logic [LEN_W-1:0] r_block_length;
    logic [LEN_W-1:0] r_vector_length;
    logic             r_busy;
    logic [POS_W-1:0] r_pos;
    logic [LEN_W-1:0] r_cnt;
    logic [POS_W-1:0] r_first;
    t_lane_cfg        r_lane [MAX_LEN];

    logic [LEN_W-1:0] bl;
    logic [LEN_W-1:0] n;
    logic [EXT_W-1:0] last_raw;
    logic [EXT_W-1:0] n_m1;
    logic [EXT_W-1:0] last_ext;
    logic [POS_W-1:0] span;
    logic [LEN_W-1:0] cnt_inc;
    logic             wrap;
    t_lane_cfg        cur;

    always_comb begin
        bl       = (r_block_length == '0) ? LEN_W'(1) : r_block_length;
        n        = (r_vector_length > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : r_vector_length;
        last_raw = EXT_W'(r_first) + EXT_W'(bl) - EXT_W'(1);
        n_m1     = EXT_W'(n) - EXT_W'(1);
        last_ext = (last_raw < n_m1) ? last_raw : n_m1;
        cur.valid     = LEN_W'(r_pos) < n;
        cur.first_pos = r_first;
        cur.last_pos  = last_ext[POS_W-1:0];
        span          = cur.last_pos - r_pos;
        cur.has_excl  = cur.valid && (span != '0);
        // excluded bit: farthest position p+1+4q still inside the block
        cur.excl_pos  = r_pos + POS_W'(1) + ((span - POS_W'(1)) & ~POS_W'(3));
        cnt_inc = r_cnt + LEN_W'(1);
        wrap    = (cnt_inc == bl);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_length  <= RST_BLOCK_LENGTH;
            r_vector_length <= RST_VECTOR_LENGTH;
            r_busy          <= 1'b1;
            r_pos           <= '0;
            r_cnt           <= '0;
            r_first         <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_BLOCK_LENGTH) begin
                r_block_length <= LEN_W'(i_cfg_data);
            end else if (i_cfg_index == CFG_VECTOR_LENGTH) begin
                r_vector_length <= LEN_W'(i_cfg_data);
            end
            r_busy  <= 1'b1;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_first <= '0;
        end else if (r_busy) begin
            r_pos <= r_pos + POS_W'(1);
            if (r_pos == POS_W'(MAX_LEN - 1)) begin
                r_busy <= 1'b0;
            end
            if (wrap) begin
                r_cnt   <= '0;
                r_first <= r_pos + POS_W'(1);
            end else begin
                r_cnt   <= cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy && !i_cfg_valid) begin
            r_lane[r_pos] <= cur;
        end
    end

    assign o_busy     = r_busy;
    assign o_lane_cfg = r_lane;

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_busy && r_pos == '0))
        else $error("register write did not restart the lane sweep");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_pos == POS_W'(MAX_LEN - 1) && !i_cfg_valid) |=> !r_busy)
        else $error("lane sweep did not end after the last position");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_busy && !i_cfg_valid) |=> !r_busy)
        else $error("sweep started without a register write");

endmodule

// File: design/ebt_lane.sv
// One bit lane of the epistasis transform: block parity from the prefix parity
// vector, XOR the excluded bit. Depends on ebt_pkg.
module ebt_lane import ebt_pkg::*; (
    input  logic [MAX_LEN-1:0] i_bits,
    input  logic [MAX_LEN-1:0] i_prefix,
    input  t_lane_cfg          i_cfg,
    output logic               o_bit
);

    logic par;
    logic below;

    always_comb begin
        below = (i_cfg.first_pos == '0) ? 1'b0 : i_prefix[i_cfg.first_pos - POS_W'(1)];
        par   = i_prefix[i_cfg.last_pos] ^ below;
        o_bit = i_cfg.valid & (par ^ (i_cfg.has_excl & i_bits[i_cfg.excl_pos]));
    end

endmodule

// File: design/block_epistasis_bit_transform_top.sv
// Epistasis bit transform, top level: prefix parity stage, 64 bit lanes, merge
// into the output register. Depends on ebt_pkg, ebt_setup, ebt_lane.
// The pipe is stage one (input and prefix parity) and the output register (lane result).
// Throughput: one vector per cycle unless held by output back-pressure or a table sweep.
// After reset and after every register write the lane table is rebuilt in a
// sweep over all 64 bit positions, one bit position per cycle; no input is taken during it.
// Reset is synchronous, active low; registers return to block 4, vector 64.
module block_epistasis_bit_transform_top import ebt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [MAX_LEN-1:0]    i_bits_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [MAX_LEN-1:0]    o_bits_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [MAX_LEN-1:0] ONES = '1;

    logic               busy;
    t_lane_cfg          lane_cfg [MAX_LEN];
    logic [MAX_LEN-1:0] prefix;
    logic [MAX_LEN-1:0] lane_bits;
    logic               advance;
    logic               in_acc;

    logic               r_s1_valid;
    logic [MAX_LEN-1:0] r_x;
    logic [MAX_LEN-1:0] r_prefix;
    logic               r_out_valid;
    logic [MAX_LEN-1:0] r_bits_out;

    ebt_setup u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (busy),
        .o_lane_cfg  (lane_cfg)
    );

    // prefix parity: bit p is the XOR of input bits 0..p
    always_comb begin
        for (int p = 0; p < MAX_LEN; p++) begin
            prefix[p] = ^(i_bits_in & (ONES >> (MAX_LEN - 1 - p)));
        end
    end

    for (genvar g = 0; g < MAX_LEN; g++) begin : g_lane
        ebt_lane u_lane (
            .i_bits   (r_x),
            .i_prefix (r_prefix),
            .i_cfg    (lane_cfg[g]),
            .o_bit    (lane_bits[g])
        );
    end

    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !busy && (!r_s1_valid || advance);
    assign in_acc     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x      <= i_bits_in;
            r_prefix <= prefix;
        end
        if (advance && r_s1_valid) begin
            r_bits_out <= lane_bits;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bits_out  = r_bits_out;
    assign o_cfg_ready = 1'b1;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !busy)
        else $error("input taken while lane table is rebuilt");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted transaction lost in stage one");

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !advance) |=> (r_s1_valid && $stable(r_x)))
        else $error("stalled stage one changed");

endmodule
